// File: src/gtg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gtg_pkg;

  // Word format: signed Q16.16
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int PROD_W     = 2 * DATA_WIDTH;
  localparam int QP_W       = PROD_W - FRAC_BITS;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic        [DATA_WIDTH-1:0] umag_t;

  localparam data_t V_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam data_t V_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // Product saturation limits on the magnitude
  localparam logic [QP_W-1:0] LIM_NEG = QP_W'(1) << (DATA_WIDTH - 1);
  localparam logic [QP_W-1:0] LIM_POS = LIM_NEG - QP_W'(1);

  // Fixed-point constants
  localparam data_t K_ONE  = data_t'(65536);
  localparam data_t K_HALF = data_t'(32768);
  localparam data_t K_A    = data_t'(52290);
  localparam data_t K_B    = data_t'(2338);
  localparam data_t K_3B   = data_t'(7014);

  // tanh datapath widths; |u| below 5.0 keeps every term inside these
  localparam int M_W  = 19;
  localparam int S_W  = 21;
  localparam int S2_W = 26;
  localparam int S3_W = 30;
  localparam int N_W  = 37;
  localparam int D_W  = 39;
  localparam int MN_W = M_W + N_W;
  localparam int Q_W  = M_W;
  localparam int T_W  = FRAC_BITS + 1;

  localparam umag_t TANH_LIMIT = umag_t'(5) << FRAC_BITS;

  // Rational tanh coefficients
  localparam logic [N_W-1:0] TANH_C0 = N_W'(135135) << FRAC_BITS;
  localparam logic [N_W-1:0] CN_1    = N_W'(17325);
  localparam logic [N_W-1:0] CN_2    = N_W'(378);
  localparam logic [D_W-1:0] CD_1    = D_W'(62370);
  localparam logic [D_W-1:0] CD_2    = D_W'(3150);
  localparam logic [D_W-1:0] CD_3    = D_W'(28);

  localparam logic [T_W-1:0] T_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // Values that ride along with the tanh evaluation
  typedef struct packed {
    data_t x;
    data_t e;
    data_t p;
    logic  uneg;
    logic  big;
  } side_t;

  function automatic umag_t mag(input data_t a);
    return a[DATA_WIDTH-1] ? umag_t'(0) - unsigned'(a) : unsigned'(a);
  endfunction

  // Q16.16 multiply, truncated toward zero, saturated
  function automatic data_t mul_sat(input data_t a, input data_t b);
    logic              neg;
    umag_t             ma;
    umag_t             mb;
    logic [PROD_W-1:0] prod;
    logic [QP_W-1:0]   q;
    logic [QP_W-1:0]   lim;
    neg  = a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
    ma   = mag(a);
    mb   = mag(b);
    prod = PROD_W'(ma) * PROD_W'(mb);
    q    = prod[PROD_W-1:FRAC_BITS];
    lim  = neg ? LIM_NEG : LIM_POS;
    if (q > lim) begin
      q = lim;
    end
    return neg ? data_t'(umag_t'(0) - q[DATA_WIDTH-1:0]) : data_t'(q[DATA_WIDTH-1:0]);
  endfunction

  // Saturating add
  function automatic data_t add_sat(input data_t a, input data_t b);
    logic signed [DATA_WIDTH:0] s;
    s = (DATA_WIDTH+1)'(a) + (DATA_WIDTH+1)'(b);
    if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
      return s[DATA_WIDTH] ? V_MIN : V_MAX;
    end
    return data_t'(s[DATA_WIDTH-1:0]);
  endfunction

endpackage

`default_nettype wire

// File: src/gtg_poly.sv
`timescale 1ns / 1ps
`default_nettype none

module gtg_poly (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  gtg_pkg::data_t            in_x,
  input  gtg_pkg::data_t            in_e,
  output logic                      out_valid,
  output gtg_pkg::side_t            out_side,
  output logic [gtg_pkg::M_W-1:0]   out_m
);
  import gtg_pkg::*;

  logic  v1_r, v2_r, v3_r, v4_r;
  data_t x1_r, e1_r, x2_r, ax1_r;
  data_t x2c_r, e2_r, ax2_r, x3_r, p3_r;
  data_t x3c_r, e3_r, ax3_r, bx3_r, p_r;
  side_t side_r;
  logic [M_W-1:0] m_r;

  data_t x2_nxt, ax_nxt, x3_nxt, p3_nxt, bx3_nxt, p_nxt, u_nxt;
  umag_t um_nxt;

  // x^2, a*x | x^3, 3b*x^2 | b*x^3, a+3b*x^2 | u and its magnitude
  always_comb begin
    x2_nxt  = mul_sat(in_x, in_x);
    ax_nxt  = mul_sat(K_A, in_x);
    x3_nxt  = mul_sat(x2_r, x1_r);
    p3_nxt  = mul_sat(K_3B, x2_r);
    bx3_nxt = mul_sat(K_B, x3_r);
    p_nxt   = add_sat(K_A, p3_r);
    u_nxt   = add_sat(ax3_r, bx3_r);
    um_nxt  = mag(u_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r        <= in_x;
      e1_r        <= in_e;
      x2_r        <= x2_nxt;
      ax1_r       <= ax_nxt;
      x2c_r       <= x1_r;
      e2_r        <= e1_r;
      ax2_r       <= ax1_r;
      x3_r        <= x3_nxt;
      p3_r        <= p3_nxt;
      x3c_r       <= x2c_r;
      e3_r        <= e2_r;
      ax3_r       <= ax2_r;
      bx3_r       <= bx3_nxt;
      p_r         <= p_nxt;
      side_r.x    <= x3c_r;
      side_r.e    <= e3_r;
      side_r.p    <= p_r;
      side_r.uneg <= u_nxt[DATA_WIDTH-1];
      side_r.big  <= (um_nxt >= TANH_LIMIT);
      m_r         <= um_nxt[M_W-1:0];
    end
  end

  assign out_valid = v4_r;
  assign out_side  = side_r;
  assign out_m     = m_r;

endmodule

`default_nettype wire

// File: src/gtg_tanh.sv
`timescale 1ns / 1ps
`default_nettype none

module gtg_tanh (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  gtg_pkg::side_t            in_side,
  input  logic [gtg_pkg::M_W-1:0]   in_m,
  output logic                      out_valid,
  output gtg_pkg::side_t            out_side,
  output logic [gtg_pkg::MN_W-1:0]  out_num,
  output logic [gtg_pkg::D_W-1:0]   out_den
);
  import gtg_pkg::*;

  logic  p5_v_r, p6_v_r, p7_v_r, p8_v_r, p9_v_r, p10_v_r;
  side_t p5_side_r, p6_side_r, p7_side_r, p8_side_r, p9_side_r, p10_side_r;
  logic [M_W-1:0]  p5_m_r, p6_m_r, p7_m_r, p8_m_r, p9_m_r;
  logic [S_W-1:0]  p5_s_r, p6_s_r;
  logic [S2_W-1:0] p6_s2_r;
  logic [N_W-1:0]  p6_sn_r, p7_sn_r, p7_s2n_r, p8_np_r, p9_n_r;
  logic [D_W-1:0]  p6_sd_r, p7_sd_r, p7_s2d_r, p8_dp_r, p9_d_r, p10_d_r;
  logic [S3_W-1:0] p7_s3_r, p8_s3_r;
  logic [MN_W-1:0] p10_mn_r;

  logic [2*M_W-1:0]      mm;
  logic [2*S_W-1:0]      ss;
  logic [S2_W+S_W-1:0]   s2s;
  logic [S_W-1:0]        s_nxt;
  logic [S2_W-1:0]       s2_nxt;
  logic [S3_W-1:0]       s3_nxt;
  logic [N_W-1:0]        sn_nxt, s2n_nxt, np_nxt, n_nxt;
  logic [D_W-1:0]        sd_nxt, s2d_nxt, dp_nxt, d_nxt;
  logic [MN_W-1:0]       mn_nxt;

  // Powers of u^2, numerator and denominator terms, then m*N
  always_comb begin
    mm      = (2*M_W)'(in_m) * (2*M_W)'(in_m);
    s_nxt   = mm[FRAC_BITS +: S_W];
    ss      = (2*S_W)'(p5_s_r) * (2*S_W)'(p5_s_r);
    s2_nxt  = ss[FRAC_BITS +: S2_W];
    sn_nxt  = N_W'(p5_s_r) * CN_1;
    sd_nxt  = D_W'(p5_s_r) * CD_1;
    s2s     = (S2_W+S_W)'(p6_s2_r) * (S2_W+S_W)'(p6_s_r);
    s3_nxt  = s2s[FRAC_BITS +: S3_W];
    s2n_nxt = N_W'(p6_s2_r) * CN_2;
    s2d_nxt = D_W'(p6_s2_r) * CD_2;
    np_nxt  = TANH_C0 + p7_sn_r + p7_s2n_r;
    dp_nxt  = D_W'(TANH_C0) + p7_sd_r + p7_s2d_r;
    n_nxt   = p8_np_r + N_W'(p8_s3_r);
    d_nxt   = p8_dp_r + D_W'(p8_s3_r) * CD_3;
    mn_nxt  = MN_W'(p9_m_r) * MN_W'(p9_n_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p5_v_r  <= 1'b0;
      p6_v_r  <= 1'b0;
      p7_v_r  <= 1'b0;
      p8_v_r  <= 1'b0;
      p9_v_r  <= 1'b0;
      p10_v_r <= 1'b0;
    end else if (en) begin
      p5_v_r  <= in_valid;
      p6_v_r  <= p5_v_r;
      p7_v_r  <= p6_v_r;
      p8_v_r  <= p7_v_r;
      p9_v_r  <= p8_v_r;
      p10_v_r <= p9_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p5_side_r  <= in_side;
      p5_m_r     <= in_m;
      p5_s_r     <= s_nxt;
      p6_side_r  <= p5_side_r;
      p6_m_r     <= p5_m_r;
      p6_s_r     <= p5_s_r;
      p6_s2_r    <= s2_nxt;
      p6_sn_r    <= sn_nxt;
      p6_sd_r    <= sd_nxt;
      p7_side_r  <= p6_side_r;
      p7_m_r     <= p6_m_r;
      p7_s3_r    <= s3_nxt;
      p7_sn_r    <= p6_sn_r;
      p7_sd_r    <= p6_sd_r;
      p7_s2n_r   <= s2n_nxt;
      p7_s2d_r   <= s2d_nxt;
      p8_side_r  <= p7_side_r;
      p8_m_r     <= p7_m_r;
      p8_s3_r    <= p7_s3_r;
      p8_np_r    <= np_nxt;
      p8_dp_r    <= dp_nxt;
      p9_side_r  <= p8_side_r;
      p9_m_r     <= p8_m_r;
      p9_n_r     <= n_nxt;
      p9_d_r     <= d_nxt;
      p10_side_r <= p9_side_r;
      p10_mn_r   <= mn_nxt;
      p10_d_r    <= p9_d_r;
    end
  end

  assign out_valid = p10_v_r;
  assign out_side  = p10_side_r;
  assign out_num   = p10_mn_r;
  assign out_den   = p10_d_r;

  // N never exceeds D, so the quotient fits the divider width
  a_num_le_den: assert property (@(posedge clk) disable iff (!rst_n)
    p9_v_r |-> (D_W'(p9_n_r) <= p9_d_r))
    else $error("tanh numerator above denominator");

endmodule

`default_nettype wire

// File: src/gtg_div.sv
`timescale 1ns / 1ps
`default_nettype none

module gtg_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  gtg_pkg::side_t            in_side,
  input  logic [gtg_pkg::MN_W-1:0]  in_num,
  input  logic [gtg_pkg::D_W-1:0]   in_den,
  output logic                      out_valid,
  output gtg_pkg::side_t            out_side,
  output logic [gtg_pkg::Q_W-1:0]   out_quo
);
  import gtg_pkg::*;

  // One restoring step per stage; lo holds unused dividend bits, quotient shifts in
  logic           v_r    [Q_W];
  side_t          side_r [Q_W];
  logic [D_W-1:0] rem_r  [Q_W];
  logic [D_W-1:0] den_r  [Q_W];
  logic [Q_W-1:0] lo_r   [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic           v_in;
    side_t          side_in;
    logic [D_W-1:0] rem_in;
    logic [D_W-1:0] den_in;
    logic [Q_W-1:0] lo_in;
    logic [D_W:0]   trial;
    logic           take;
    logic [D_W-1:0] rem_nxt;
    logic [Q_W-1:0] lo_nxt;

    if (k == 0) begin : g_head
      assign v_in    = in_valid;
      assign side_in = in_side;
      assign rem_in  = D_W'(in_num[MN_W-1:Q_W]);
      assign den_in  = in_den;
      assign lo_in   = in_num[Q_W-1:0];
    end else begin : g_link
      assign v_in    = v_r[k-1];
      assign side_in = side_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign den_in  = den_r[k-1];
      assign lo_in   = lo_r[k-1];
    end

    // trial subtract
    always_comb begin
      trial   = {rem_in, lo_in[Q_W-1]};
      take    = (trial >= (D_W+1)'(den_in));
      rem_nxt = take ? D_W'(trial - (D_W+1)'(den_in)) : D_W'(trial);
      lo_nxt  = {lo_in[Q_W-2:0], take};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= side_in;
        rem_r[k]  <= rem_nxt;
        den_r[k]  <= den_in;
        lo_r[k]   <= lo_nxt;
      end
    end
  end

  assign out_valid = v_r[Q_W-1];
  assign out_side  = side_r[Q_W-1];
  assign out_quo   = lo_r[Q_W-1];

  // Remainder left by the last step stays below the divisor
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[Q_W-1] |-> (rem_r[Q_W-1] < den_r[Q_W-1]))
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

// File: src/gtg_back.sv
`timescale 1ns / 1ps
`default_nettype none

module gtg_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  gtg_pkg::side_t            in_side,
  input  logic [gtg_pkg::Q_W-1:0]   in_quo,
  output logic                      out_valid,
  output gtg_pkg::data_t            out_gradient
);
  import gtg_pkg::*;

  logic  b1_v_r, b2_v_r, b3_v_r, b4_v_r, b5_v_r, b6_v_r, b7_v_r;
  side_t b1_side_r;
  logic [T_W-1:0] b1_tm_r;
  data_t b2_x_r, b2_e_r, b2_p_r, b2_sech_r, b2_f0_r;
  data_t b3_e_r, b3_p_r, b3_f0_r, b3_xs_r;
  data_t b4_e_r, b4_f0_r, b4_q_r;
  data_t b5_e_r, b5_f1_r;
  data_t b6_e_r, b6_f_r;
  data_t b7_g_r;

  logic [T_W-1:0]   tm_nxt;
  logic [2*T_W-1:0] tsq;
  data_t            t_val;
  data_t            sech_nxt, f0_nxt, xs_nxt, q_nxt, f1_nxt, f_nxt, g_nxt;

  // tanh clamp, sech^2 and 1+tanh, then the product chain
  always_comb begin
    if (in_side.big || (in_quo > Q_W'(T_ONE))) begin
      tm_nxt = T_ONE;
    end else begin
      tm_nxt = T_W'(in_quo);
    end
    tsq      = (2*T_W)'(b1_tm_r) * (2*T_W)'(b1_tm_r);
    sech_nxt = data_t'(T_ONE - tsq[FRAC_BITS +: T_W]);
    t_val    = b1_side_r.uneg ? data_t'(0) - data_t'(b1_tm_r) : data_t'(b1_tm_r);
    f0_nxt   = add_sat(K_ONE, t_val);
    xs_nxt   = mul_sat(b2_x_r, b2_sech_r);
    q_nxt    = mul_sat(b3_xs_r, b3_p_r);
    f1_nxt   = add_sat(b4_f0_r, b4_q_r);
    f_nxt    = mul_sat(b5_f1_r, K_HALF);
    g_nxt    = mul_sat(b6_f_r, b6_e_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
      b3_v_r <= 1'b0;
      b4_v_r <= 1'b0;
      b5_v_r <= 1'b0;
      b6_v_r <= 1'b0;
      b7_v_r <= 1'b0;
    end else if (en) begin
      b1_v_r <= in_valid;
      b2_v_r <= b1_v_r;
      b3_v_r <= b2_v_r;
      b4_v_r <= b3_v_r;
      b5_v_r <= b4_v_r;
      b6_v_r <= b5_v_r;
      b7_v_r <= b6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_side_r <= in_side;
      b1_tm_r   <= tm_nxt;
      b2_x_r    <= b1_side_r.x;
      b2_e_r    <= b1_side_r.e;
      b2_p_r    <= b1_side_r.p;
      b2_sech_r <= sech_nxt;
      b2_f0_r   <= f0_nxt;
      b3_e_r    <= b2_e_r;
      b3_p_r    <= b2_p_r;
      b3_f0_r   <= b2_f0_r;
      b3_xs_r   <= xs_nxt;
      b4_e_r    <= b3_e_r;
      b4_f0_r   <= b3_f0_r;
      b4_q_r    <= q_nxt;
      b5_e_r    <= b4_e_r;
      b5_f1_r   <= f1_nxt;
      b6_e_r    <= b5_e_r;
      b6_f_r    <= f_nxt;
      b7_g_r    <= g_nxt;
    end
  end

  assign out_valid    = b7_v_r;
  assign out_gradient = b7_g_r;

  a_tanh_le_one: assert property (@(posedge clk) disable iff (!rst_n)
    b1_v_r |-> (b1_tm_r <= T_ONE))
    else $error("tanh magnitude above one");

  a_sech_range: assert property (@(posedge clk) disable iff (!rst_n)
    b2_v_r |-> (!b2_sech_r[DATA_WIDTH-1] && (b2_sech_r <= K_ONE)))
    else $error("sech^2 out of range");

endmodule

`default_nettype wire

// File: src/gelu_tanh_gradient_core.sv
// Throughput: one word per cycle while out_ready does not hold the output; tanh is a
// rational fit whose division runs as a 19-stage restoring pipeline, one quotient bit per stage.
// A result word held by out_ready low stalls every stage; nothing is dropped.
// Reset: rst_n low at a clock edge (synchronous) clears all stage valid bits.
`timescale 1ns / 1ps
`default_nettype none

module gelu_tanh_gradient_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  gtg_pkg::data_t  in_x_sample,
  input  gtg_pkg::data_t  in_upstream_error,
  output logic            out_valid,
  input  logic            out_ready,
  output gtg_pkg::data_t  out_gradient
);
  import gtg_pkg::*;

  logic            en;
  logic            poly_valid, tanh_valid, div_valid;
  side_t           poly_side, tanh_side, div_side;
  logic [M_W-1:0]  poly_m;
  logic [MN_W-1:0] tanh_num;
  logic [D_W-1:0]  tanh_den;
  logic [Q_W-1:0]  div_quo;

  // Whole pipeline advances unless the output word is held
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  gtg_poly u_poly (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_x      (in_x_sample),
    .in_e      (in_upstream_error),
    .out_valid (poly_valid),
    .out_side  (poly_side),
    .out_m     (poly_m)
  );

  gtg_tanh u_tanh (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (poly_valid),
    .in_side   (poly_side),
    .in_m      (poly_m),
    .out_valid (tanh_valid),
    .out_side  (tanh_side),
    .out_num   (tanh_num),
    .out_den   (tanh_den)
  );

  gtg_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (tanh_valid),
    .in_side   (tanh_side),
    .in_num    (tanh_num),
    .in_den    (tanh_den),
    .out_valid (div_valid),
    .out_side  (div_side),
    .out_quo   (div_quo)
  );

  gtg_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (div_valid),
    .in_side      (div_side),
    .in_quo       (div_quo),
    .out_valid    (out_valid),
    .out_gradient (out_gradient)
  );

endmodule

`default_nettype wire
